@@ design/gnss_tracking_loop_filter_defines.svh @@
// ----------------------------------------------------------------------------
// gnss tracking loop filter assertion macros
// concurrent assertion helpers, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef GNSS_TRACKING_LOOP_FILTER_DEFINES_SVH
`define GNSS_TRACKING_LOOP_FILTER_DEFINES_SVH

// same-cycle implication
`define GTLF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GTLF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/gtlf_pkg.sv @@
// ----------------------------------------------------------------------------
// gtlf_pkg
// shared widths, codes and types of the gnss tracking loop filter
// ----------------------------------------------------------------------------
`default_nettype none

package gtlf_pkg;

	localparam int DATA_WIDTH     = 32;
	localparam int COEF_WIDTH     = 32;
	localparam int COEF_FRAC_BITS = 20;
	localparam int FIELD_WIDTH    = 32;
	localparam int RATIO_WIDTH    = 31;
	localparam int ACTION_WIDTH   = 2;
	localparam int REG_IDX_WIDTH  = 3;
	localparam int STEP_WIDTH     = 4;

	// item kinds
	localparam logic [ACTION_WIDTH-1:0] ACT_UPDATE = 2'd0;
	localparam logic [ACTION_WIDTH-1:0] ACT_ADJUST = 2'd1;
	localparam logic [ACTION_WIDTH-1:0] ACT_LOAD   = 2'd2;
	localparam logic [ACTION_WIDTH-1:0] ACT_NONE   = 2'd3;

	// register indexes
	localparam logic [REG_IDX_WIDTH-1:0] REG_PLL_COEF_ZERO = 3'd0;
	localparam logic [REG_IDX_WIDTH-1:0] REG_PLL_COEF_ONE  = 3'd1;
	localparam logic [REG_IDX_WIDTH-1:0] REG_PLL_COEF_TWO  = 3'd2;
	localparam logic [REG_IDX_WIDTH-1:0] REG_FLL_COEF_ZERO = 3'd3;
	localparam logic [REG_IDX_WIDTH-1:0] REG_FLL_COEF_ONE  = 3'd4;
	localparam logic [REG_IDX_WIDTH-1:0] REG_DLL_COEF_ZERO = 3'd5;
	localparam logic [REG_IDX_WIDTH-1:0] REG_DLL_COEF_ONE  = 3'd6;
	localparam logic [REG_IDX_WIDTH-1:0] REG_AIDING_RATIO  = 3'd7;

	// operand pair for the shared multiplier
	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] data;
		logic signed [COEF_WIDTH-1:0] coef;
	} mul_op_t;

endpackage

`default_nettype wire

@@ design/gtlf_mul_unit.sv @@
// ----------------------------------------------------------------------------
// gtlf_mul_unit
// shared fixed-point multiplier: data times coefficient, floor shift by the
// coefficient fraction bits, wrapped to the data width, registered
// ----------------------------------------------------------------------------
`default_nettype none

module gtlf_mul_unit (
	input  wire                              clk,
	input  wire gtlf_pkg::mul_op_t           op,
	output logic signed [gtlf_pkg::DATA_WIDTH-1:0] prod_q
);
	import gtlf_pkg::*;

	logic signed [DATA_WIDTH+COEF_WIDTH-1:0] full;

	assign full = op.data * op.coef;

	always_ff @(posedge clk) begin
		prod_q <= full[COEF_FRAC_BITS +: DATA_WIDTH];
	end

endmodule

`default_nettype wire

@@ design/gnss_tracking_loop_filter.sv @@
// ----------------------------------------------------------------------------
// gnss_tracking_loop_filter
// third-order carrier pll with fll assist and first-order code dll with
// carrier aiding, all products on one shared multiplier
// ----------------------------------------------------------------------------
//  channel   signals                        use
//  s_*       tvalid tready tdata tuser      items in (update, adjust, load)
//  m_*       tvalid tready tdata            filter state after each item
//  wr_*      en index data                  coefficient register writes
//
//  an update runs in steps from acceptance to a valid result: eight products go in
//  turn through the shared multiplier, with a step for the carrier
//  integration and a final step for the aided code frequency
//  adjust, load and the unused code give their result in the cycle after acceptance
//  a new item is taken only when idle and the output slot is empty or draining
//  arst_n clears the coefficient and filter registers, state and the output valid
// ----------------------------------------------------------------------------
`default_nettype none

module gnss_tracking_loop_filter (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// phase err, freq err, code err, carr_value, code_value, accel_value
	input  wire [191:0] s_tdata,
	// action
	input  wire [1:0]   s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// carrier_freq, code_freq_out, code_integral, accel_per_step
	output logic [127:0] m_tdata,
	input  wire         wr_en,
	input  wire [gtlf_pkg::REG_IDX_WIDTH-1:0] wr_index,
	input  wire [gtlf_pkg::COEF_WIDTH-1:0]    wr_data
);
	import gtlf_pkg::*;

`include "gnss_tracking_loop_filter_defines.svh"

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	localparam logic [STEP_WIDTH-1:0] STEP_ISSUE_P0  = 4'd0;
	localparam logic [STEP_WIDTH-1:0] STEP_ACC_P0    = 4'd1;
	localparam logic [STEP_WIDTH-1:0] STEP_ACC_P1    = 4'd2;
	localparam logic [STEP_WIDTH-1:0] STEP_ACC_P2    = 4'd3;
	localparam logic [STEP_WIDTH-1:0] STEP_CARR      = 4'd4;
	localparam logic [STEP_WIDTH-1:0] STEP_ACC_F0    = 4'd5;
	localparam logic [STEP_WIDTH-1:0] STEP_ACC_F1    = 4'd6;
	localparam logic [STEP_WIDTH-1:0] STEP_ACC_D0    = 4'd7;
	localparam logic [STEP_WIDTH-1:0] STEP_ACC_D1    = 4'd8;
	localparam logic [STEP_WIDTH-1:0] STEP_CODE_FREQ = 4'd9;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [COEF_WIDTH-1:0] coef_t;
	typedef logic signed [FIELD_WIDTH-1:0] field_t;

	logic                    state_q;
	logic [STEP_WIDTH-1:0]   step_q;
	logic                    m_tvalid_q;

	coef_t                   pll0_q, pll1_q, pll2_q, fll0_q, fll1_q, dll0_q, dll1_q;
	logic [RATIO_WIDTH-1:0]  ratio_q;

	data_t phase_hist_one_q, phase_hist_two_q, freq_hist_q, code_hist_q;
	data_t accel_sum_q, carrier_sum_q, code_sum_q, code_freq_q;
	data_t pe_q, fe_q, ce_q;

	logic [ACTION_WIDTH-1:0] action;
	data_t                   in_pe, in_fe, in_ce, in_carr, in_code, in_accel;
	logic                    s_accept;
	logic                    m_take;
	logic                    m_set;
	logic                    last_step;
	logic                    fll_en;
	mul_op_t                 mul_op;
	data_t                   prod;

	assign action   = s_tuser;
	assign in_pe    = DATA_WIDTH'(field_t'(s_tdata[31:0]));
	assign in_fe    = DATA_WIDTH'(field_t'(s_tdata[63:32]));
	assign in_ce    = DATA_WIDTH'(field_t'(s_tdata[95:64]));
	assign in_carr  = DATA_WIDTH'(field_t'(s_tdata[127:96]));
	assign in_code  = DATA_WIDTH'(field_t'(s_tdata[159:128]));
	assign in_accel = DATA_WIDTH'(field_t'(s_tdata[191:160]));

	assign m_take    = m_tvalid_q && m_tready;
	assign s_tready  = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign s_accept  = s_tvalid && s_tready;
	assign last_step = (state_q == ST_RUN) && (step_q == STEP_CODE_FREQ);
	assign m_set     = (s_accept && action != ACT_UPDATE) || last_step;
	assign fll_en    = (fll0_q != '0) && (fe_q != '0);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {FIELD_WIDTH'(accel_sum_q), FIELD_WIDTH'(code_sum_q),
	                   FIELD_WIDTH'(code_freq_q), FIELD_WIDTH'(carrier_sum_q)};

	// operand selection, at most one product issued per step
	always_comb begin
		mul_op.data = '0;
		mul_op.coef = '0;
		unique case (step_q)
			STEP_ISSUE_P0: begin
				mul_op.data = pe_q;
				mul_op.coef = pll0_q;
			end
			STEP_ACC_P0: begin
				mul_op.data = phase_hist_one_q;
				mul_op.coef = pll1_q;
			end
			STEP_ACC_P1: begin
				mul_op.data = phase_hist_two_q;
				mul_op.coef = pll2_q;
			end
			STEP_CARR: begin
				mul_op.data = fe_q;
				mul_op.coef = fll0_q;
			end
			STEP_ACC_F0: begin
				mul_op.data = freq_hist_q;
				mul_op.coef = fll1_q;
			end
			STEP_ACC_F1: begin
				mul_op.data = ce_q;
				mul_op.coef = dll0_q;
			end
			STEP_ACC_D0: begin
				mul_op.data = code_hist_q;
				mul_op.coef = dll1_q;
			end
			STEP_ACC_D1: begin
				mul_op.data = carrier_sum_q;
				mul_op.coef = COEF_WIDTH'(ratio_q);
			end
			default: begin
				mul_op.data = '0;
				mul_op.coef = '0;
			end
		endcase
	end

	gtlf_mul_unit u_mul (
		.clk    (clk),
		.op     (mul_op),
		.prod_q (prod)
	);

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pll0_q  <= '0;
			pll1_q  <= '0;
			pll2_q  <= '0;
			fll0_q  <= '0;
			fll1_q  <= '0;
			dll0_q  <= '0;
			dll1_q  <= '0;
			ratio_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PLL_COEF_ZERO: pll0_q  <= wr_data;
				REG_PLL_COEF_ONE:  pll1_q  <= wr_data;
				REG_PLL_COEF_TWO:  pll2_q  <= wr_data;
				REG_FLL_COEF_ZERO: fll0_q  <= wr_data;
				REG_FLL_COEF_ONE:  fll1_q  <= wr_data;
				REG_DLL_COEF_ZERO: dll0_q  <= wr_data;
				REG_DLL_COEF_ONE:  dll1_q  <= wr_data;
				REG_AIDING_RATIO:  ratio_q <= wr_data[RATIO_WIDTH-1:0];
				default:           ratio_q <= ratio_q;
			endcase
		end
	end

	// latched discriminator outputs
	always_ff @(posedge clk) begin
		if (s_accept && action == ACT_UPDATE) begin
			pe_q <= in_pe;
			fe_q <= in_fe;
			ce_q <= in_ce;
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			step_q           <= STEP_ISSUE_P0;
			m_tvalid_q       <= 1'b0;
			phase_hist_one_q <= '0;
			phase_hist_two_q <= '0;
			freq_hist_q      <= '0;
			code_hist_q      <= '0;
			accel_sum_q      <= '0;
			carrier_sum_q    <= '0;
			code_sum_q       <= '0;
			code_freq_q      <= '0;
		end else begin
			priority if (m_set) begin
				m_tvalid_q <= 1'b1;
			end else if (m_take) begin
				m_tvalid_q <= 1'b0;
			end else begin
				m_tvalid_q <= m_tvalid_q;
			end
			if (s_accept) begin
				unique case (action)
					ACT_UPDATE: begin
						state_q <= ST_RUN;
						step_q  <= STEP_ISSUE_P0;
					end
					ACT_ADJUST: begin
						carrier_sum_q <= carrier_sum_q + in_carr;
						code_sum_q    <= code_sum_q + in_code;
						code_hist_q   <= '0;
					end
					ACT_LOAD: begin
						phase_hist_one_q <= '0;
						phase_hist_two_q <= '0;
						freq_hist_q      <= '0;
						code_hist_q      <= '0;
						accel_sum_q      <= in_accel;
						carrier_sum_q    <= in_carr;
						code_sum_q       <= in_code;
						code_freq_q      <= in_code;
					end
					ACT_NONE: begin
					end
				endcase
			end else if (state_q == ST_RUN) begin
				step_q <= last_step ? STEP_ISSUE_P0 : step_q + 1'b1;
				unique case (step_q)
					STEP_ACC_P0, STEP_ACC_P1, STEP_ACC_P2: begin
						accel_sum_q <= accel_sum_q + prod;
					end
					STEP_CARR: begin
						carrier_sum_q <= carrier_sum_q + accel_sum_q;
					end
					STEP_ACC_F0, STEP_ACC_F1: begin
						if (fll_en) begin
							carrier_sum_q <= carrier_sum_q + prod;
						end
					end
					STEP_ACC_D0, STEP_ACC_D1: begin
						code_sum_q <= code_sum_q + prod;
					end
					STEP_CODE_FREQ: begin
						// aiding term is zero when the ratio is zero
						code_freq_q      <= code_sum_q + prod;
						phase_hist_two_q <= phase_hist_one_q;
						phase_hist_one_q <= pe_q;
						code_hist_q      <= ce_q;
						if (fll_en) begin
							freq_hist_q <= fe_q;
						end
						state_q <= ST_IDLE;
					end
					default: begin
					end
				endcase
			end
		end
	end

	`GTLF_ASSERT_NEXT(a_update_starts, s_accept && action == ACT_UPDATE,
		state_q == ST_RUN && step_q == STEP_ISSUE_P0 && !m_tvalid_q,
		"update did not start the sequence")
	`GTLF_ASSERT_NOW(a_no_result_while_run, state_q == ST_RUN, !m_tvalid_q && !s_tready,
		"result or ready shown during a running update")
	`GTLF_ASSERT_NEXT(a_last_step_result, last_step, m_tvalid_q && state_q == ST_IDLE,
		"update finished without a result")
	`GTLF_ASSERT_NEXT(a_direct_result, s_accept && action != ACT_UPDATE,
		m_tvalid_q && state_q == ST_IDLE, "direct item gave no result")

endmodule

`default_nettype wire
